[hw/rtl/mss_pkg.sv]
// types and constants shared by the multi-stack shared store unit
package mss_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;
  localparam int SID_W      = 2;
  localparam int VAL_W      = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

[hw/rtl/multi_stack_shared_store_unit.sv]
// top level: several stacks sharing one slot store through a linked free list
//
// Each beat on the slave side is a push or a pop on one stack and yields one
// result beat. An item is taken in every cycle while results are taken, and
// its result is registered after the item stage: at acceptance the slot
// address (free list head for a push, stack top for a pop) selects the
// synchronous reads of the link and value stores, and when the item
// advances it commits its pointer and store updates and loads the result
// register. The next item's addresses are taken from the pointers being
// committed, and a read of the slot written in the same cycle is bypassed,
// so back-to-back operations on one stack are exact. The link store needs
// no clearing after reset: slots above a fill mark still hold their reset
// chain, which the logic supplies itself.
module multi_stack_shared_store_unit #(
  parameter int NUM_STACKS  = 4,
  parameter int STORE_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // stack_id [1:0], push_value [33:2], zero pad [39:34]
  input  logic [mss_pkg::IN_DATA_W-1:0]   s_tdata,
  // command [0]
  input  logic [mss_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pop_value [31:0]
  output logic [mss_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status [1:0]
  output logic [mss_pkg::OUT_USER_W-1:0]  m_tuser
);
  import mss_pkg::*;

  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(STORE_DEPTH);

  // stores
  logic [PW-1:0]         link_mem  [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] value_mem [STORE_DEPTH];

  // pointer state
  logic [PW-1:0] tops      [NUM_STACKS];
  logic [PW-1:0] tops_next [NUM_STACKS];
  logic [PW-1:0] free_head, free_head_next;
  logic [PW-1:0] fill, fill_next;

  // item stage
  logic                  valid1;
  cmd_t                  cmd1;
  logic [SW-1:0]         sidx1;
  logic                  sid_ok1;
  logic [DATA_WIDTH-1:0] val1;
  logic [PW-1:0]         link_rd;
  logic [DATA_WIDTH-1:0] value_rd;
  logic                  fwd_link_hit, fwd_value_hit;
  logic [PW-1:0]         fwd_link_data;
  logic [DATA_WIDTH-1:0] fwd_value_data;

  // result register
  status_t           status_q;
  logic [VAL_W-1:0]  pop_q;

  // input decode
  cmd_t                  in_cmd;
  logic [SID_W-1:0]      in_sid;
  logic [VAL_W-1:0]      in_val;
  logic [SW+SID_W-1:0]   in_sid_wide;
  logic [SW-1:0]         in_sidx;
  logic                  in_sid_ok;
  logic [63:0]           in_val64;
  logic [PW-1:0]         raddr;
  logic                  accept, adv;

  // commit logic
  logic [PW-1:0]         link_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [PW-1:0]         cur_top;
  logic                  fresh;
  logic                  push_ok, pop_ok, commit, value_we;
  logic [PW-1:0]         nxt, wslot, link_wdata, top_wdata, fh_new, fill_new;
  status_t               res_status;
  logic [VAL_W-1:0]      res_pop;
  logic signed [63:0]    pop_ext;

  assign in_cmd      = cmd_t'(s_tuser[0]);
  assign in_sid      = s_tdata[SID_W-1:0];
  assign in_val      = s_tdata[SID_W+VAL_W-1:SID_W];
  assign in_sid_wide = {SW'(0), in_sid};
  assign in_sidx     = in_sid_wide[SW-1:0];
  assign in_sid_ok   = 32'(in_sid) < 32'(NUM_STACKS);
  assign in_val64    = {32'b0, in_val};

  assign adv      = valid1 && (!m_tvalid || m_tready);
  assign s_tready = !valid1 || adv;
  assign accept   = s_tvalid && s_tready;

  assign link_q  = fwd_link_hit ? fwd_link_data : link_rd;
  assign value_q = fwd_value_hit ? fwd_value_data : value_rd;
  assign cur_top = tops[sidx1];
  assign fresh   = free_head == fill;
  assign pop_ext = 64'(signed'(value_q));

  always_comb begin
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    res_status = ST_OK;
    res_pop    = '0;
    nxt        = link_q;
    wslot      = free_head;
    link_wdata = cur_top;
    top_wdata  = free_head;
    fh_new     = free_head;
    fill_new   = fill;
    case (cmd1)
      CMD_PUSH: begin
        push_ok    = sid_ok1 && (free_head < NULL_PTR);
        res_status = push_ok ? ST_OK : ST_FULL;
        // slots at the fill mark still carry their reset link
        nxt        = fresh ? (fill + PW'(1)) : link_q;
        wslot      = free_head;
        link_wdata = cur_top;
        top_wdata  = free_head;
        fh_new     = (nxt < NULL_PTR) ? nxt : NULL_PTR;
        fill_new   = fresh ? (fill + PW'(1)) : fill;
      end
      CMD_POP: begin
        pop_ok     = sid_ok1 && (cur_top < NULL_PTR);
        res_status = pop_ok ? ST_OK : ST_EMPTY;
        res_pop    = pop_ok ? pop_ext[VAL_W-1:0] : '0;
        wslot      = cur_top;
        link_wdata = free_head;
        top_wdata  = (link_q < NULL_PTR) ? link_q : NULL_PTR;
        fh_new     = cur_top;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign commit         = adv && (push_ok || pop_ok);
  assign value_we       = adv && push_ok;
  assign free_head_next = commit ? fh_new : free_head;
  assign fill_next      = value_we ? fill_new : fill;

  for (genvar i = 0; i < NUM_STACKS; i++) begin : g_tops
    assign tops_next[i] = (commit && sidx1 == SW'(i)) ? top_wdata : tops[i];
  end

  // read address from the pointers as they stand after this cycle's commit
  assign raddr = (in_cmd == CMD_POP) ? tops_next[in_sidx] : free_head_next;

  always_ff @(posedge clk) begin
    if (commit) begin
      link_mem[wslot[AW-1:0]] <= link_wdata;
    end
    if (value_we) begin
      value_mem[wslot[AW-1:0]] <= val1;
    end
    if (accept) begin
      link_rd  <= link_mem[raddr[AW-1:0]];
      value_rd <= value_mem[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1           <= in_cmd;
      sidx1          <= in_sidx;
      sid_ok1        <= in_sid_ok;
      val1           <= in_val64[DATA_WIDTH-1:0];
      fwd_link_hit   <= commit && (raddr == wslot);
      fwd_link_data  <= link_wdata;
      fwd_value_hit  <= value_we && (raddr == wslot);
      fwd_value_data <= val1;
    end
    if (adv) begin
      status_q <= res_status;
      pop_q    <= res_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      m_tvalid  <= 1'b0;
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops[i] <= NULL_PTR;
      end
    end else begin
      if (accept) begin
        valid1 <= 1'b1;
      end else if (adv) begin
        valid1 <= 1'b0;
      end
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      free_head <= free_head_next;
      fill      <= fill_next;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops[i] <= tops_next[i];
      end
    end
  end

  assign m_tdata = pop_q;
  assign m_tuser = status_q;

  // free list head never points into the untouched region above the fill mark
  a_head_below_fill: assert property (@(posedge clk) disable iff (rst)
    free_head <= fill)
    else $error("free list head above fill mark");

  // a good push makes the old free head the new top of its stack
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    (adv && push_ok) |=> tops[$past(sidx1)] == $past(free_head))
    else $error("push did not update stack top");

  // a stalled item stays in the stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (valid1 && !adv) |=> valid1)
    else $error("stalled item lost");

  // failed operations return zero data (pushes also return zero, not checked here)
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tdata == '0)
    else $error("nonzero data on failed operation");

endmodule

[test/tb.sv]
// testbench for multi_stack_shared_store_unit: random push and pop traffic
module tb;
  import mss_pkg::*;

  localparam int NUM_STACKS  = 4;
  localparam int STORE_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam logic [6:0] SLOT_NULL = 7'(STORE_DEPTH);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } stack_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  multi_stack_shared_store_unit #(
    .NUM_STACKS (NUM_STACKS),
    .STORE_DEPTH(STORE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // store model
  logic [31:0] slot_value [STORE_DEPTH];
  logic [6:0]  slot_link  [STORE_DEPTH];
  logic [6:0]  top_of     [NUM_STACKS];
  logic [6:0]  free_head;

  stack_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic void clear_store_model();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      slot_value[i] = '0;
      slot_link[i]  = 7'(i + 1);
    end
    slot_link[STORE_DEPTH-1] = SLOT_NULL;
    for (int i = 0; i < NUM_STACKS; i++) top_of[i] = SLOT_NULL;
    free_head = '0;
  endfunction

  function automatic stack_result_t apply_stack_op(cmd_t cmd, logic [1:0] sid,
                                                   logic [31:0] val);
    stack_result_t r;
    logic [6:0] slot;
    logic [6:0] nxt;
    r.status = ST_OK;
    r.value  = '0;
    if (cmd == CMD_PUSH) begin
      if (free_head >= SLOT_NULL) begin
        r.status = ST_FULL;
      end else begin
        slot = free_head;
        nxt = slot_link[slot[5:0]];
        free_head = (nxt < SLOT_NULL) ? nxt : SLOT_NULL;
        slot_value[slot[5:0]] = val;
        slot_link[slot[5:0]] = top_of[sid];
        top_of[sid] = slot;
      end
    end else begin
      if (top_of[sid] >= SLOT_NULL) begin
        r.status = ST_EMPTY;
      end else begin
        slot = top_of[sid];
        nxt = slot_link[slot[5:0]];
        top_of[sid] = (nxt < SLOT_NULL) ? nxt : SLOT_NULL;
        slot_link[slot[5:0]] = free_head;
        free_head = slot;
        r.value = slot_value[slot[5:0]];
      end
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    stack_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: status %0d value %h", m_tuser, m_tdata);
      end else begin
        exp = pending_results.pop_front();
        if (m_tuser !== exp.status || m_tdata !== exp.value) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d value %h, got status %0d value %h",
                     exp.status, exp.value, m_tuser, m_tdata);
        end
      end
    end
  end

  task automatic send_op(input cmd_t cmd, input logic [1:0] sid, input logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, val, sid};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_stack_op(cmd, sid, val));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_traffic(input int n, input int push_pct);
    cmd_t cmd;
    logic [31:0] val;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      case ($urandom_range(0, 15))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'hffff_ffff;
        3: val = 32'h0000_0000;
        default: val = $urandom;
      endcase
      send_op(cmd, 2'($urandom_range(0, NUM_STACKS - 1)), val);
    end
  endtask

  task automatic test_edge_values();
    send_op(CMD_PUSH, 2'd0, 32'h8000_0000);
    send_op(CMD_PUSH, 2'd1, 32'h7fff_ffff);
    send_op(CMD_PUSH, 2'd2, 32'h0000_0000);
    send_op(CMD_PUSH, 2'd3, 32'hffff_ffff);
    send_op(CMD_PUSH, 2'd0, 32'h5555_5555);
    send_op(CMD_PUSH, 2'd0, 32'haaaa_aaaa);
    send_op(CMD_POP,  2'd0, 32'hffff_ffff);
    send_op(CMD_POP,  2'd0, 32'h0);
    send_op(CMD_POP,  2'd0, 32'h0);
    // push then pop straight away on one stack
    send_op(CMD_PUSH, 2'd2, 32'h1234_5678);
    send_op(CMD_POP,  2'd2, 32'h0);
    for (int s = 1; s < NUM_STACKS; s++) send_op(CMD_POP, 2'(s), 32'h0);
  endtask

  task automatic test_empty_stacks();
    for (int s = 0; s < NUM_STACKS; s++) send_op(CMD_POP, 2'(s), 32'hdead_beef);
  endtask

  task automatic test_fill_and_drain();
    run_traffic(130, 90);
    run_traffic(130, 10);
  endtask

  task automatic test_mixed_traffic();
    run_traffic(120, 55);
  endtask

  task automatic run_idle_mode(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    test_fill_and_drain();
    wait_drained();
    test_mixed_traffic();
    wait_drained();
  endtask

  initial begin
    clear_store_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = 7;
    rx_idle_pct = 45;
    test_edge_values();
    test_empty_stacks();
    wait_drained();
    run_idle_mode(7, 45);
    run_idle_mode(45, 7);
    run_idle_mode(0, 0);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
